// ===== hdl/hht_pkg.sv =====
// Package for the heartbeat health table.
// Holds the operation codes, health codes, queue word and result types.
// Used by hht_front, hht_back and heartbeat_health_table.
package hht_pkg;

	localparam int MaxRegions = 64;

	localparam logic [2:0] FUNC_REGISTER  = 3'd0;
	localparam logic [2:0] FUNC_HEARTBEAT = 3'd1;
	localparam logic [2:0] FUNC_TICK      = 3'd2;
	localparam logic [2:0] FUNC_SET_STATE = 3'd3;
	localparam logic [2:0] FUNC_LOOKUP    = 3'd4;

	localparam logic [2:0] H_HEALTHY     = 3'd0;
	localparam logic [2:0] H_SUSPECT     = 3'd1;
	localparam logic [2:0] H_OFFLINE     = 3'd2;
	localparam logic [2:0] H_DRAINING    = 3'd3;
	localparam logic [2:0] H_QUARANTINED = 3'd4;

	localparam logic [1:0] NS_HEALTHY     = 2'd0;
	localparam logic [1:0] NS_DRAINING    = 2'd1;
	localparam logic [1:0] NS_QUARANTINED = 2'd2;

	typedef enum logic [2:0] {
		OP_REG  = 3'd0,
		OP_HB   = 3'd1,
		OP_TICK = 3'd2,
		OP_SET  = 3'd3,
		OP_LOOK = 3'd4,
		OP_NONE = 3'd5
	} op_t;

	typedef struct packed {
		op_t         op;
		logic [31:0] key;
		logic [31:0] epoch;
		logic [47:0] now;
		logic [1:0]  ns;
	} item_t;

	typedef struct packed {
		logic        valid;
		logic [31:0] key;
		logic [31:0] epoch;
		logic [47:0] last;
		logic [2:0]  health;
	} rec_t;

	typedef struct packed {
		logic        found;
		logic        changed;
		logic [2:0]  state;
		logic        can_alloc;
		logic        can_read;
		logic [31:0] epoch;
		logic [47:0] last;
		logic        full;
	} res_t;

	typedef struct packed {
		logic init_done;
		logic busy;
	} bk_stat_t;

	function automatic op_t classify(input logic [2:0] func);
		op_t op;
		case (func)
			FUNC_REGISTER:  op = OP_REG;
			FUNC_HEARTBEAT: op = OP_HB;
			FUNC_TICK:      op = OP_TICK;
			FUNC_SET_STATE: op = OP_SET;
			FUNC_LOOKUP:    op = OP_LOOK;
			default:        op = OP_NONE;
		endcase
		return op;
	endfunction

endpackage

// ===== hdl/hht_front.sv =====
// Front part of the heartbeat health table: accepts input words,
// decodes the operation and queues them for the back part (two-entry queue).
// Depends on hht_pkg.
module hht_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [2:0]          func,
	input  logic [15:0]         node_id,
	input  logic [15:0]         owner_id,
	input  logic [31:0]         epoch,
	input  logic [47:0]         now_ms,
	input  logic [1:0]          new_state,
	input  hht_pkg::bk_stat_t   stat,
	output logic                q_valid,
	output hht_pkg::item_t      q_item,
	input  logic                q_pop
);

	hht_pkg::item_t fifo_q [2];
	logic           wp_q;
	logic           rp_q;
	logic [1:0]     cnt_q;
	logic           push;

	assign in_ready = stat.init_done && (cnt_q != 2'd2);
	assign push     = in_valid && in_ready;
	assign q_valid  = (cnt_q != 2'd0);
	assign q_item   = fifo_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wp_q].op    <= hht_pkg::classify(func);
			fifo_q[wp_q].key   <= {node_id, owner_id};
			fifo_q[wp_q].epoch <= epoch;
			fifo_q[wp_q].now   <= now_ms;
			fifo_q[wp_q].ns    <= new_state;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (q_pop && q_valid) rp_q <= ~rp_q;
			case ({push, q_pop && q_valid})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ===== hdl/hht_back.sv =====
// Back part of the heartbeat health table: slot memory, clearing pass,
// per-word sweep over all slots and the result register.
// Depends on hht_pkg.
module hht_back #(
	parameter int MAX_REGIONS = hht_pkg::MaxRegions
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [31:0]       suspect_after,
	input  logic [31:0]       offline_after,
	input  logic              q_valid,
	input  hht_pkg::item_t    q_item,
	output logic              q_pop,
	output hht_pkg::bk_stat_t stat,
	output logic              out_valid,
	input  logic              out_ready,
	output hht_pkg::res_t     res
);

	localparam int AW = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
	localparam logic [AW:0]   NumSlots = (AW + 1)'(MAX_REGIONS);
	localparam logic [AW-1:0] LastIdx  = AW'(MAX_REGIONS - 1);

	typedef enum logic [3:0] {
		ST_CLEAR  = 4'b0001,
		ST_IDLE   = 4'b0010,
		ST_SWEEP  = 4'b0100,
		ST_FINISH = 4'b1000
	} st_t;

	hht_pkg::rec_t  mem [MAX_REGIONS];
	st_t            st_q;
	logic [AW:0]    cnt_q;
	logic           rd_v_s1;
	logic [AW-1:0]  rd_idx_s1;
	hht_pkg::rec_t  rd_rec_s1;
	hht_pkg::item_t item_q;
	logic           hit_q;
	logic [AW-1:0]  hit_idx_q;
	hht_pkg::rec_t  hit_rec_q;
	logic           free_q;
	logic [AW-1:0]  free_idx_q;
	logic           ch_q;
	logic           out_valid_q;
	hht_pkg::res_t  res_q;

	logic           rd_en;
	logic           we;
	logic [AW-1:0]  wa;
	hht_pkg::rec_t  wd;
	logic [47:0]    gap;
	logic           tick_wr;
	logic [2:0]     tick_h;
	logic           fin_go;
	logic           fin_wr;
	logic [AW-1:0]  fin_idx;
	hht_pkg::rec_t  fin_rec;
	hht_pkg::res_t  fin_res;
	logic           key_hit;

	assign q_pop          = (st_q == ST_IDLE) && q_valid;
	assign stat.init_done = (st_q != ST_CLEAR);
	assign stat.busy      = (st_q == ST_SWEEP) || (st_q == ST_FINISH);
	assign out_valid      = out_valid_q;
	assign res            = res_q;
	assign rd_en          = (st_q == ST_SWEEP) && (cnt_q < NumSlots);
	assign fin_go         = (st_q == ST_FINISH) && (!out_valid_q || out_ready);
	assign key_hit        = rd_rec_s1.valid && (rd_rec_s1.key == item_q.key);

	// tick demotion of the slot read last cycle
	always_comb begin
		gap     = item_q.now - rd_rec_s1.last;
		tick_wr = 1'b0;
		tick_h  = rd_rec_s1.health;
		if (st_q == ST_SWEEP && rd_v_s1 && item_q.op == hht_pkg::OP_TICK &&
		    rd_rec_s1.valid && item_q.now >= rd_rec_s1.last &&
		    (rd_rec_s1.health inside {hht_pkg::H_HEALTHY, hht_pkg::H_SUSPECT,
		                              hht_pkg::H_OFFLINE})) begin
			if (gap >= {16'd0, offline_after}) begin
				if (rd_rec_s1.health != hht_pkg::H_OFFLINE) begin
					tick_wr = 1'b1;
					tick_h  = hht_pkg::H_OFFLINE;
				end
			end else if (gap >= {16'd0, suspect_after}) begin
				if (rd_rec_s1.health == hht_pkg::H_HEALTHY) begin
					tick_wr = 1'b1;
					tick_h  = hht_pkg::H_SUSPECT;
				end
			end
		end
	end

	// final update and report
	always_comb begin
		fin_wr  = 1'b0;
		fin_idx = hit_idx_q;
		fin_rec = hit_rec_q;
		fin_res = '0;
		case (item_q.op)
			hht_pkg::OP_REG: begin
				if (hit_q || free_q) begin
					fin_wr        = 1'b1;
					fin_idx       = hit_q ? hit_idx_q : free_idx_q;
					fin_rec.valid = 1'b1;
					fin_rec.key   = item_q.key;
					fin_rec.epoch = item_q.epoch;
					fin_rec.last  = item_q.now;
					fin_rec.health = (item_q.ns == hht_pkg::NS_QUARANTINED) ?
					                 hht_pkg::H_QUARANTINED : hht_pkg::H_HEALTHY;
				end else begin
					fin_res.full = 1'b1;
				end
			end
			hht_pkg::OP_HB: begin
				if (hit_q) begin
					fin_wr       = 1'b1;
					fin_rec.last = item_q.now;
					if (item_q.epoch != hit_rec_q.epoch) begin
						fin_rec.health  = hht_pkg::H_QUARANTINED;
						fin_rec.epoch   = item_q.epoch;
						fin_res.changed = 1'b1;
					end else if (hit_rec_q.health inside {hht_pkg::H_SUSPECT,
					                                      hht_pkg::H_OFFLINE}) begin
						fin_rec.health  = hht_pkg::H_HEALTHY;
						fin_res.changed = 1'b1;
					end
				end
			end
			hht_pkg::OP_TICK: fin_res.changed = ch_q;
			hht_pkg::OP_SET: begin
				if (hit_q) begin
					fin_wr = 1'b1;
					case (item_q.ns)
						hht_pkg::NS_HEALTHY:     fin_rec.health = hht_pkg::H_HEALTHY;
						hht_pkg::NS_DRAINING:    fin_rec.health = hht_pkg::H_DRAINING;
						hht_pkg::NS_QUARANTINED: fin_rec.health = hht_pkg::H_QUARANTINED;
						default:                 fin_rec.health = hit_rec_q.health;
					endcase
				end
			end
			default: ;
		endcase
		if ((item_q.op == hht_pkg::OP_REG && (hit_q || free_q)) ||
		    ((item_q.op inside {hht_pkg::OP_HB, hht_pkg::OP_SET, hht_pkg::OP_LOOK}) &&
		     hit_q)) begin
			fin_res.found     = 1'b1;
			fin_res.state     = fin_rec.health;
			fin_res.can_alloc = (fin_rec.health == hht_pkg::H_HEALTHY);
			fin_res.can_read  = (fin_rec.health inside {hht_pkg::H_HEALTHY,
			                     hht_pkg::H_SUSPECT, hht_pkg::H_DRAINING});
			fin_res.epoch     = fin_rec.epoch;
			fin_res.last      = fin_rec.last;
		end
	end

	always_comb begin
		we = 1'b0;
		wa = cnt_q[AW-1:0];
		wd = '0;
		if (st_q == ST_CLEAR) begin
			we = 1'b1;
		end else if (tick_wr) begin
			we        = 1'b1;
			wa        = rd_idx_s1;
			wd        = rd_rec_s1;
			wd.health = tick_h;
		end else if (fin_go && fin_wr) begin
			we = 1'b1;
			wa = fin_idx;
			wd = fin_rec;
		end
	end

	always_ff @(posedge clk) begin
		if (we) mem[wa] <= wd;
		if (rd_en) rd_rec_s1 <= mem[cnt_q[AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (rd_en) rd_idx_s1 <= cnt_q[AW-1:0];
		if (q_pop) item_q <= q_item;
		if (q_pop) begin
			hit_q  <= 1'b0;
			free_q <= 1'b0;
			ch_q   <= 1'b0;
		end else if (st_q == ST_SWEEP && rd_v_s1) begin
			if (key_hit && !hit_q) begin
				hit_q     <= 1'b1;
				hit_idx_q <= rd_idx_s1;
				hit_rec_q <= rd_rec_s1;
			end
			if (!rd_rec_s1.valid && !free_q) begin
				free_q     <= 1'b1;
				free_idx_q <= rd_idx_s1;
			end
			if (tick_wr) ch_q <= 1'b1;
		end
		if (fin_go) res_q <= fin_res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_CLEAR;
			cnt_q       <= '0;
			rd_v_s1     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rd_v_s1 <= rd_en;
			if (fin_go) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
			case (st_q)
				ST_CLEAR: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q[AW-1:0] == LastIdx) st_q <= ST_IDLE;
				end
				ST_IDLE: begin
					cnt_q <= '0;
					if (q_valid) st_q <= ST_SWEEP;
				end
				ST_SWEEP: begin
					if (rd_en) cnt_q <= cnt_q + 1'b1;
					if (rd_v_s1 && rd_idx_s1 == LastIdx) st_q <= ST_FINISH;
				end
				ST_FINISH: begin
					if (fin_go) st_q <= ST_IDLE;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ===== hdl/heartbeat_health_table.sv =====
// Heartbeat health table, top level.
// Holds the threshold registers and joins hht_front and hht_back.
// Depends on hht_pkg, hht_front, hht_back.
//
// Usage: input words (func, node_id, owner_id, epoch, now_ms, new_state)
// enter on in_valid/in_ready; one result word leaves per input word on
// out_valid/out_ready. Thresholds are written through cfg_we, cfg_index
// (0 suspect_after, 1 offline_after) and cfg_data; the user must write
// them only while the block is idle, which the block does not enforce.
// Every word sweeps all MAX_REGIONS slots of the slot memory (one read
// and one write port), one slot a cycle, then makes its update in the
// finish state; the next word leaves the queue only after that update.
// A two-word queue sits in front of the sweep engine, so input words are
// taken while a word is being processed or a result waits.
// After reset a clearing pass over all MAX_REGIONS slots empties the table;
// in_ready stays low during it. When the receiver stalls, the result is
// held in the output register and the engine waits before its next update;
// the queue keeps accepting until it holds two words.
module heartbeat_health_table #(
	parameter int MAX_REGIONS = hht_pkg::MaxRegions
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  func,
	input  logic [15:0] node_id,
	input  logic [15:0] owner_id,
	input  logic [31:0] epoch,
	input  logic [47:0] now_ms,
	input  logic [1:0]  new_state,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        found,
	output logic        changed,
	output logic [2:0]  entry_state,
	output logic        can_allocate,
	output logic        can_read,
	output logic [31:0] stored_epoch,
	output logic [47:0] last_beat_ms,
	output logic        table_full
);

	logic [31:0]       suspect_after_q;
	logic [31:0]       offline_after_q;
	logic              q_valid;
	logic              q_pop;
	hht_pkg::item_t    q_item;
	hht_pkg::bk_stat_t stat;
	hht_pkg::res_t     res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			suspect_after_q <= 32'd3000;
			offline_after_q <= 32'd10000;
		end else if (cfg_we) begin
			if (cfg_index == 1'b0) suspect_after_q <= cfg_data;
			else offline_after_q <= cfg_data;
		end
	end

	hht_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.func      (func),
		.node_id   (node_id),
		.owner_id  (owner_id),
		.epoch     (epoch),
		.now_ms    (now_ms),
		.new_state (new_state),
		.stat      (stat),
		.q_valid   (q_valid),
		.q_item    (q_item),
		.q_pop     (q_pop)
	);

	hht_back #(.MAX_REGIONS(MAX_REGIONS)) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.suspect_after (suspect_after_q),
		.offline_after (offline_after_q),
		.q_valid       (q_valid),
		.q_item        (q_item),
		.q_pop         (q_pop),
		.stat          (stat),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.res           (res)
	);

	assign found        = res.found;
	assign changed      = res.changed;
	assign entry_state  = res.state;
	assign can_allocate = res.can_alloc;
	assign can_read     = res.can_read;
	assign stored_epoch = res.epoch;
	assign last_beat_ms = res.last;
	assign table_full   = res.full;

	a_full_not_found: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && table_full |-> !found) else $error("full with found");
	a_alloc_healthy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && can_allocate |-> can_read && entry_state == hht_pkg::H_HEALTHY)
		else $error("allocate on unhealthy entry");
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !found |-> stored_epoch == 32'd0 && last_beat_ms == 48'd0 &&
		entry_state == hht_pkg::H_HEALTHY) else $error("miss with payload");
	a_no_ready_in_clear: assert property (@(posedge clk)
		!arst_n |=> !in_ready) else $error("ready during clearing pass");

endmodule
